FILE: sv/sms_pkg.sv
package sms_pkg;

  localparam int BLOB_PITCH = 8;
  localparam int DEEP_RUNS = 3 * BLOB_PITCH;
  localparam int DEEP_IW = $clog2(DEEP_RUNS);

  localparam int QUEUE_AW = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [15:0] FULL = 16'hffff;
  localparam logic [15:0] EDGE_LO = 16'd1229;
  localparam logic [15:0] EDGE_HI = 16'd2458;
  localparam logic [17:0] S_BASE = 18'd196605;
  localparam logic [15:0] OPAQUE_MIN = 16'd1311;
  localparam logic [9:0] RUN_MAX = 10'd1023;

  // floor(n / d) as (n * recip) >> shift, exact over the operand range
  localparam logic [26:0] T_RECIP = 27'd111829906;
  localparam int T_SHIFT = 37;
  localparam logic [20:0] W_RECIP = 21'd1677722;
  localparam int W_SHIFT = 25;
  localparam logic [16:0] ALPHA_RECIP = 17'd65281;
  localparam int ALPHA_SHIFT = 24;

  localparam logic [31:0] HASH_X = 32'd374761393;
  localparam logic [31:0] HASH_Y = 32'd668265263;
  localparam logic [31:0] HASH_MIX = 32'd1274126177;
  localparam logic [15:0] GRAIN_BASE = 16'd30147;
  localparam logic [12:0] GRAIN_SPAN = 13'd5243;

  typedef logic [7:0] rgb_t [3];
  localparam rgb_t DRY_TOP = '{8'd235, 8'd200, 8'd130};
  localparam rgb_t DRY_DEEP = '{8'd175, 8'd140, 8'd75};
  localparam rgb_t WET_COL = '{8'd110, 8'd85, 8'd55};

  typedef struct packed {
    logic        column_start;
    logic [15:0] sand_coverage;
    logic [15:0] wetness;
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
  } sms_in_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } sms_out_t;

  typedef struct packed {
    logic        opaque;
    logic [7:0]  alpha;
    logic [15:0] deep;
    logic [15:0] wet;
    logic [15:0] grain;
  } sms_mid_t;

  typedef logic [15:0] deep_lut_t [DEEP_RUNS];

  function automatic deep_lut_t deep_lut_init();
    deep_lut_t lut;
    for (int i = 0; i < DEEP_RUNS; i++) begin
      lut[i] = 16'((i * 65535) / DEEP_RUNS);
    end
    return lut;
  endfunction

  localparam deep_lut_t DEEP_LUT = deep_lut_init();

  function automatic logic [15:0] deep_frac(input logic [9:0] run);
    logic [15:0] d;
    if (run >= 10'(DEEP_RUNS)) begin
      d = FULL;
    end else begin
      d = DEEP_LUT[run[DEEP_IW-1:0]];
    end
    return d;
  endfunction

  // floor(n / 65535): n = h*65536 + l = h*65535 + (h + l), folded three times
  function automatic logic [34:0] div_ffff(input logic [49:0] n);
    logic [34:0] r1;
    logic [19:0] r2;
    logic [16:0] r3;
    logic [34:0] q;
    r1 = 35'(n[49:16]) + 35'(n[15:0]);
    r2 = 20'(r1[34:16]) + 20'(r1[15:0]);
    r3 = 17'(r2[19:16]) + 17'(r2[15:0]);
    q = 35'(n[49:16]) + 35'(r1[34:16]) + 35'(r2[19:16]) + 35'(r3 >= 17'(FULL));
    return q;
  endfunction

endpackage

FILE: sv/sms_front.sv
module sms_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sms_pkg::sms_in_t  in_req,
  output logic              mid_valid,
  input  logic              mid_stall,
  output sms_pkg::sms_mid_t mid_req
);
  import sms_pkg::*;

  logic        adv;
  logic [5:0]  v_r, v_nxt;
  logic [4:0]  start_r, start_nxt;
  logic [15:0] wet_r [5];
  logic [15:0] wet_nxt [5];

  logic [11:0] t_d;
  logic [27:0] t_num;
  logic [54:0] t_prod;
  logic [39:0] hx, hy;
  logic [20:0] w17;
  logic [41:0] w_prod;
  logic [15:0] t1_r, t1_nxt;
  logic [31:0] h1_r, h1_nxt;

  logic [63:0] hmix;
  logic [31:0] tt2_r, tt2_nxt;
  logic [17:0] s2_r, s2_nxt;
  logic [31:0] h2_r, h2_nxt;

  logic [15:0] h16;
  logic [49:0] na3_r, na3_nxt;
  logic [28:0] gp3_r, gp3_nxt;

  logic [34:0] q4_r, q4_nxt;
  logic [15:0] grain4_r, grain4_nxt;

  logic [15:0] a5_r, a5_nxt;
  logic [15:0] grain5_r;

  logic        opaque;
  logic [32:0] a_prod;
  logic [9:0]  run_base, run_inc, depth_run_r, depth_run_nxt;
  sms_mid_t    mid_r, mid_nxt;

  assign adv = !(v_r[5] && mid_stall);
  assign in_stall = !adv;
  assign mid_valid = v_r[5];
  assign mid_req = mid_r;
  assign v_nxt = {v_r[4:0], in_valid};

  always_comb begin
    start_nxt = {start_r[3:0], in_req.column_start};
    wet_nxt[0] = 16'd0;
    for (int i = 1; i < 5; i++) begin
      wet_nxt[i] = wet_r[i-1];
    end

    // smoothstep argument
    t_d = 12'(in_req.sand_coverage - EDGE_LO);
    t_num = {t_d, 16'b0} - 28'(t_d);
    t_prod = t_num * T_RECIP;
    priority if (in_req.sand_coverage <= EDGE_LO) begin
      t1_nxt = '0;
    end else if (in_req.sand_coverage >= EDGE_HI) begin
      t1_nxt = FULL;
    end else begin
      t1_nxt = t_prod[T_SHIFT+15:T_SHIFT];
    end

    hx = in_req.pixel_x[8:1] * HASH_X;
    hy = in_req.pixel_y[8:1] * HASH_Y;
    h1_nxt = hx[31:0] + hy[31:0];

    w17 = {1'b0, in_req.wetness, 4'b0} + 21'(in_req.wetness);
    w_prod = w17 * W_RECIP;
    wet_nxt[0] = w_prod[W_SHIFT+15:W_SHIFT];
  end

  always_comb begin
    tt2_nxt = t1_r * t1_r;
    s2_nxt = S_BASE - 18'({t1_r, 1'b0});
    hmix = (h1_r ^ (h1_r >> 13)) * HASH_MIX;
    h2_nxt = hmix[31:0];

    na3_nxt = tt2_r * s2_r;
    h16 = h2_r[15:0] ^ h2_r[31:16];
    gp3_nxt = h16 * GRAIN_SPAN;

    q4_nxt = div_ffff(na3_r);
    grain4_nxt = GRAIN_BASE + 16'(div_ffff(50'(gp3_r)));

    a5_nxt = 16'(div_ffff(50'(q4_r)));
  end

  always_comb begin
    opaque = a5_r >= OPAQUE_MIN;
    a_prod = a5_r * ALPHA_RECIP;
    run_base = start_r[4] ? '0 : depth_run_r;
    run_inc = (run_base == RUN_MAX) ? run_base : run_base + 10'd1;
    depth_run_nxt = opaque ? run_inc : '0;
    mid_nxt.opaque = opaque;
    mid_nxt.alpha = a_prod[ALPHA_SHIFT+7:ALPHA_SHIFT];
    mid_nxt.deep = deep_frac(depth_run_nxt);
    mid_nxt.wet = wet_r[4];
    mid_nxt.grain = grain5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      depth_run_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
      if (v_r[4]) begin
        depth_run_r <= depth_run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      start_r <= start_nxt;
      for (int i = 0; i < 5; i++) begin
        wet_r[i] <= wet_nxt[i];
      end
      t1_r <= t1_nxt;
      h1_r <= h1_nxt;
      tt2_r <= tt2_nxt;
      s2_r <= s2_nxt;
      h2_r <= h2_nxt;
      na3_r <= na3_nxt;
      gp3_r <= gp3_nxt;
      q4_r <= q4_nxt;
      grain4_r <= grain4_nxt;
      a5_r <= a5_nxt;
      grain5_r <= grain4_r;
      mid_r <= mid_nxt;
    end
  end

endmodule

FILE: sv/sms_fifo.sv
module sms_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_stall,
  input  sms_pkg::sms_mid_t push_req,
  output logic              pop_valid,
  input  logic              pop_stall,
  output sms_pkg::sms_mid_t pop_req
);
  import sms_pkg::*;

  sms_mid_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     count_r, count_nxt;
  logic                  push, pop;

  assign push_stall = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign push = push_valid && !push_stall;
  assign pop = pop_valid && !pop_stall;
  assign pop_req = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    unique case ({push, pop})
      2'b10: count_nxt = count_r + (QUEUE_AW+1)'(1);
      2'b01: count_nxt = count_r - (QUEUE_AW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

endmodule

FILE: sv/sms_back.sv
module sms_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_stall,
  input  sms_pkg::sms_mid_t q_req,
  output logic              out_valid,
  input  logic              out_stall,
  output sms_pkg::sms_out_t out_req
);
  import sms_pkg::*;

  logic        adv;
  logic [3:0]  bv_r, bv_nxt;
  logic        out_v_r;
  sms_mid_t    item_r [4];
  sms_out_t    out_r, out_nxt;

  logic [7:0]         drop [3];
  logic [23:0]        m1 [3];
  logic [23:0]        n1_r [3];
  logic [23:0]        n1_nxt [3];
  logic [7:0]         c2_r [3];
  logic [7:0]         c2_nxt [3];
  logic signed [8:0]  dd [3];
  logic signed [26:0] pr [3];
  logic [23:0]        base3 [3];
  logic signed [26:0] sum3 [3];
  logic [23:0]        n3_r [3];
  logic [23:0]        n3_nxt [3];
  logic [7:0]         c4_r [3];
  logic [7:0]         c4_nxt [3];
  logic [23:0]        sp [3];
  logic [7:0]         ch [3];

  assign adv = !(out_v_r && out_stall);
  assign q_stall = !adv;
  assign out_valid = out_v_r;
  assign out_req = out_r;
  assign bv_nxt = {bv_r[2:0], q_valid};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      // depth blend, top colour towards deep colour
      drop[c] = DRY_TOP[c] - DRY_DEEP[c];
      m1[c] = 24'(drop[c]) * 24'(q_req.deep);
      n1_nxt[c] = ({DRY_TOP[c], 16'b0} - 24'(DRY_TOP[c])) - m1[c];
      c2_nxt[c] = 8'(div_ffff(50'(n1_r[c])));

      // wetness blend, may move either way
      dd[c] = $signed({1'b0, WET_COL[c]}) - $signed({1'b0, c2_r[c]});
      pr[c] = dd[c] * $signed({1'b0, item_r[1].wet});
      base3[c] = {c2_r[c], 16'b0} - 24'(c2_r[c]);
      sum3[c] = $signed({3'b0, base3[c]}) + pr[c];
      n3_nxt[c] = sum3[c][23:0];
      c4_nxt[c] = 8'(div_ffff(50'(n3_r[c])));

      sp[c] = 24'(c4_r[c]) * 24'(item_r[3].grain);
      ch[c] = sp[c][23] ? 8'hff : sp[c][22:15];
    end
  end

  always_comb begin
    out_nxt = '0;
    if (item_r[3].opaque) begin
      out_nxt.alpha = item_r[3].alpha;
      out_nxt.red = ch[0];
      out_nxt.green = ch[1];
      out_nxt.blue = ch[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      bv_r <= bv_nxt;
      out_v_r <= bv_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r[0] <= q_req;
      for (int i = 1; i < 4; i++) begin
        item_r[i] <= item_r[i-1];
      end
      for (int c = 0; c < 3; c++) begin
        n1_r[c] <= n1_nxt[c];
        c2_r[c] <= c2_nxt[c];
        n3_r[c] <= n3_nxt[c];
        c4_r[c] <= c4_nxt[c];
      end
      out_r <= out_nxt;
    end
  end

endmodule

FILE: sv/sand_metaball_shader.sv
// Throughput: one request per cycle when nothing stalls; front pipe of six stages,
// a four-entry queue, then a back pipe of five stages ending in the output register.
// Reset: synchronous, active low; clears valids, the queue and the depth run.
module sand_metaball_shader (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sms_pkg::sms_in_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output sms_pkg::sms_out_t out_req
);
  import sms_pkg::*;

  logic     f_valid, f_stall;
  sms_mid_t f_req;
  logic     b_valid, b_stall;
  sms_mid_t b_req;

  sms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .mid_valid (f_valid),
    .mid_stall (f_stall),
    .mid_req   (f_req)
  );

  sms_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_req   (f_req),
    .pop_valid  (b_valid),
    .pop_stall  (b_stall),
    .pop_req    (b_req)
  );

  sms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (b_valid),
    .q_stall   (b_stall),
    .q_req     (b_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule

FILE: verif/sms_checker.sv
`timescale 1ns / 1ps
module sms_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  sms_pkg::sms_in_t  in_req,
  input  logic              out_valid,
  input  logic              out_stall,
  input  sms_pkg::sms_out_t out_req,
  output int                fail_count,
  output int                pending
);
  import sms_pkg::*;

  localparam int unsigned ONE = 65535;
  localparam int unsigned RUN_LIMIT = 1023;

  sms_out_t shaded_q[$];
  bit [9:0] run_len;

  task automatic report_mismatch(input string msg);
    if (fail_count < 50) $display("%0t: shaded pixel mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic bit [31:0] mix(input bit [31:0] p, input bit [31:0] q,
                                    input bit [31:0] f);
    if (q >= p) return (p * ONE + (q - p) * f) / ONE;
    return (p * ONE - (p - q) * f) / ONE;
  endfunction

  function automatic bit [7:0] tone(input bit [31:0] top, input bit [31:0] bot,
                                    input bit [31:0] wetc, input bit [31:0] deep,
                                    input bit [31:0] wet, input bit [31:0] grain);
    bit [31:0] c;
    c = (mix(mix(top, bot, deep), wetc, wet) * grain) >> 15;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  // updates the column run as a side effect
  function automatic sms_out_t shade_pixel(input sms_in_t px);
    sms_out_t res;
    bit [31:0] cov, t, a, deep, wet, grain, hx, hy, h;
    bit [63:0] cube;
    res = '0;
    cov = 32'(px.sand_coverage);
    if (px.column_start) run_len = '0;
    if (cov <= 1229) t = 0;
    else if (cov >= 2458) t = ONE;
    else t = (cov - 1229) * ONE / 1229;
    cube = 64'(t) * 64'(t) * 64'(3 * ONE - 2 * t);
    a = 32'(cube / (64'(ONE) * 64'(ONE)));
    if (50 * a < ONE) begin
      run_len = '0;
      return res;
    end
    if (run_len < RUN_LIMIT) run_len = run_len + 10'd1;
    deep = 32'(run_len) * ONE / 32'(3 * BLOB_PITCH);
    if (deep > ONE) deep = ONE;
    wet = 32'(px.wetness) * 32'd17 / 32'd20;
    hx = 32'(px.pixel_x) >> 1;
    hy = 32'(px.pixel_y) >> 1;
    h = hx * 32'd374761393 + hy * 32'd668265263;
    h = (h ^ (h >> 13)) * 32'd1274126177;
    h = h ^ (h >> 16);
    grain = 32'd30147 + 32'd5243 * (h & 32'hffff) / ONE;
    res.alpha = 8'(32'd255 * a / ONE);
    res.red = tone(235, 175, 110, deep, wet, grain);
    res.green = tone(200, 140, 85, deep, wet, grain);
    res.blue = tone(130, 75, 55, deep, wet, grain);
    return res;
  endfunction

  // sampled mid-cycle: what is seen here is what the next rising edge takes
  always @(negedge clk) begin : watch
    sms_out_t want, got;
    if (!rst_n) begin
      shaded_q.delete();
      run_len = '0;
    end else begin
      if (in_valid && !in_stall) shaded_q.push_back(shade_pixel(in_req));
      if (out_valid && !out_stall) begin
        got = out_req;
        if (shaded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected request %h", got));
        end else begin
          want = shaded_q.pop_front();
          if (got.alpha !== want.alpha)
            report_mismatch($sformatf("alpha %h, want %h", got.alpha, want.alpha));
          if (got.red !== want.red)
            report_mismatch($sformatf("red %h, want %h", got.red, want.red));
          if (got.green !== want.green)
            report_mismatch($sformatf("green %h, want %h", got.green, want.green));
          if (got.blue !== want.blue)
            report_mismatch($sformatf("blue %h, want %h", got.blue, want.blue));
        end
      end
    end
    pending = shaded_q.size();
  end

endmodule

FILE: verif/tb_sand_metaball_shader.sv
`timescale 1ns / 1ps
module tb_sand_metaball_shader;
  import sms_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sms_in_t  in_req;
  logic     out_valid;
  logic     out_stall;
  sms_out_t out_req;

  int fail_count;
  int pending;
  int sent;
  int gap_pct;
  int stall_pct;
  int stall_left;
  int quiet;
  bit calm;

  always #5 clk = ~clk;

  sand_metaball_shader u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  sms_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_req    (out_req),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver stalls in bursts of random length, each started with a stall_pct percent chance
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(16, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic sms_in_t pixel(input bit start, input bit [15:0] cov,
                                    input bit [15:0] wet, input bit [8:0] x,
                                    input bit [8:0] y);
    sms_in_t p;
    p.column_start = start;
    p.sand_coverage = cov;
    p.wetness = wet;
    p.pixel_x = x;
    p.pixel_y = y;
    return p;
  endfunction

  function automatic bit [15:0] pick_coverage();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 16'($urandom_range(2458, 1400));
    if (pick < 70) return 16'($urandom_range(65535, 2458));
    if (pick < 88) return 16'($urandom_range(1400, 0));
    return 16'($urandom_range(65535, 0));
  endfunction

  function automatic bit [15:0] pick_wetness();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'hffff;
    return 16'($urandom_range(65535, 0));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 8;
      default: return 35;
    endcase
  endfunction

  // returns at the edge that takes the request; valid stays high
  task automatic send_request(input sms_in_t req);
    bit stalled;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
  endtask

  task automatic send_column(input int height);
    bit [8:0] x, y;
    bit start;
    x = 9'($urandom_range(511));
    y = 9'($urandom_range(511));
    for (int i = 0; i < height; i++) begin
      start = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
      if ($urandom_range(19) == 0)
        send_request(pixel(start, pick_coverage(), pick_wetness(),
                           9'($urandom_range(511)), 9'($urandom_range(511))));
      else
        send_request(pixel(start, pick_coverage(), pick_wetness(), x, y));
      y++;
    end
  endtask

  initial begin : stimulus
    bit [8:0] x, y;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    calm = 1'b0;
    gap_pct = 0;
    stall_pct = 15;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // opacity edges, threshold, extremes, run restarts
    send_request(pixel(1'b1, 16'd0, 16'd0, 9'd0, 9'd0));
    send_request(pixel(1'b0, 16'hffff, 16'hffff, 9'd511, 9'd511));
    send_request(pixel(1'b0, 16'd1229, 16'd12345, 9'd2, 9'd3));
    send_request(pixel(1'b0, 16'd1230, 16'd0, 9'd510, 9'd1));
    send_request(pixel(1'b0, 16'd1320, 16'd0, 9'd7, 9'd5));
    send_request(pixel(1'b0, 16'd1325, 16'hffff, 9'd7, 9'd6));
    send_request(pixel(1'b0, 16'd1330, 16'd0, 9'd7, 9'd7));
    send_request(pixel(1'b0, 16'd1335, 16'd32768, 9'd7, 9'd8));
    send_request(pixel(1'b0, 16'd1340, 16'd0, 9'd7, 9'd9));
    send_request(pixel(1'b0, 16'd2457, 16'hffff, 9'd7, 9'd10));
    send_request(pixel(1'b0, 16'd2458, 16'd0, 9'd7, 9'd11));
    send_request(pixel(1'b0, 16'd2459, 16'd1, 9'd7, 9'd12));
    send_request(pixel(1'b1, 16'hffff, 16'd0, 9'd8, 9'd0));
    send_request(pixel(1'b0, 16'h8000, 16'hfffe, 9'd8, 9'd1));
    send_request(pixel(1'b0, 16'h4000, 16'd100, 9'd8, 9'd2));
    send_request(pixel(1'b1, 16'hffff, 16'hffff, 9'd511, 9'd0));
    send_request(pixel(1'b0, 16'd0, 16'hffff, 9'd511, 9'd1));
    send_request(pixel(1'b0, 16'd3000, 16'd0, 9'd511, 9'd2));
    send_request(pixel(1'b1, 16'd0, 16'd0, 9'd0, 9'd511));
    send_request(pixel(1'b0, 16'hffff, 16'd0, 9'd256, 9'd256));

    // short and tall columns with noise
    while (sent < 570) begin
      gap_pct = pick_pct();
      stall_pct <= pick_pct();
      send_column(($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(20, 1));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    // one long opaque run to saturate the depth counter
    x = 9'($urandom_range(511));
    y = '0;
    for (int i = 0; i < 1100; i++) begin
      if (i % 100 == 0) begin
        gap_pct = pick_pct();
        stall_pct <= pick_pct();
      end
      send_request(pixel(i == 0, 16'($urandom_range(65535, 1400)), pick_wetness(), x, y));
      y++;
    end

    calm <= 1'b1;
    gap_pct = 0;
    while (sent < 1950) send_column($urandom_range(30, 1));

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
